@@ rtl/wav_chunk_parser_defines.svh @@
`ifndef WAV_CHUNK_PARSER_DEFINES_SVH
`define WAV_CHUNK_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define WCP_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("wav_chunk_parser: forbidden condition seen");
`define WCP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wav_chunk_parser: implication failed");
`else
`define WCP_ASSERT_NEVER(label, clk, rst, cond)
`define WCP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/wcp_pkg.sv @@
package wcp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIG,
    PH_HDR,
    PH_SKIP,
    PH_FMT,
    PH_DATA
  } phase_t;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] MIN_LEN = 32'd44;
  localparam logic [31:0] FMT_MIN = 32'd16;
  localparam logic [4:0]  FMT_OFS_MAX = 5'd16;

  localparam logic [15:0] FMT_PCM = 16'd1;
  localparam logic [15:0] CH_MONO = 16'd1;
  localparam logic [15:0] BITS_8  = 16'd8;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_NO_RIFF  = 3'd2;
  localparam logic [2:0] ST_NO_WAVE  = 3'd3;
  localparam logic [2:0] ST_NO_CHUNK = 3'd4;
  localparam logic [2:0] ST_NOT_PCM  = 3'd5;
  localparam logic [2:0] ST_NOT_MONO = 3'd6;
  localparam logic [2:0] ST_NOT_8BIT = 3'd7;

  localparam logic KIND_PCM    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic        kind;
    logic        last;
    logic [7:0]  pcm_byte;
    logic [2:0]  status;
    logic [31:0] pcm_rate;
    logic [31:0] pcm_length;
  } result_t;

endpackage

@@ rtl/wav_chunk_parser.sv @@
// A taken byte writes at most two results (data byte and report) into the result queue.
// Throughput: one byte per cycle while s_tready is high.
// A four-entry result queue parts the sides; input is held off while fewer than two slots
// are free, so a sustained one-result-per-cycle flow never stalls the input.
// Reset (rst, synchronous): parser idle, file_length zero, result queue empty.
`include "wav_chunk_parser_defines.svh"

module wav_chunk_parser
  import wcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] file_byte
  input  logic        s_tuser,    // [0] first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,    // [7:0] pcm_byte, [10:8] status, [42:11] pcm_rate,
                                  // [74:43] pcm_length, [79:75] zero
  output logic        m_tuser,    // [0] kind
  output logic        m_tlast     // last
);

  logic [31:0] file_length;

  phase_t      phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [63:0] header_shift, header_shift_next;
  logic [32:0] bytes_left, bytes_left_next;
  logic [15:0] format_code, format_code_next;
  logic [15:0] channel_count, channel_count_next;
  logic [31:0] rate_value, rate_value_next;
  logic [15:0] sample_bits, sample_bits_next;
  logic        fmt_seen, fmt_seen_next;
  logic [31:0] pcm_count, pcm_count_next;
  logic [4:0]  body_offset, body_offset_next;

  logic        s_fire;
  logic        go;
  logic        rep;
  logic [2:0]  rep_st;
  logic        pcm_out;
  logic [31:0] cur;
  logic [32:0] nxt;
  logic        hdr_fits;
  logic [31:0] tag;
  logic [31:0] size;
  logic [33:0] room;
  logic [32:0] dlen;
  logic [32:0] skip;
  logic [7:0]  b;

  result_t              res_pcm, res_rep, res0, res1;
  logic                 push0, push1;
  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_AW:0]     count;
  logic                 pop;
  result_t              head;

  assign s_tready = (count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
  assign s_fire   = s_tvalid && s_tready;
  assign b        = s_tdata;

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    header_shift_next  = header_shift;
    bytes_left_next    = bytes_left;
    format_code_next   = format_code;
    channel_count_next = channel_count;
    rate_value_next    = rate_value;
    sample_bits_next   = sample_bits;
    fmt_seen_next      = fmt_seen;
    pcm_count_next     = pcm_count;
    body_offset_next   = body_offset;
    rep     = 1'b0;
    rep_st  = ST_OK;
    pcm_out = 1'b0;
    go      = 1'b0;
    cur     = byte_position;

    if (s_fire) begin
      if (s_tuser) begin
        phase_next         = PH_IDLE;
        byte_position_next = '0;
        header_shift_next  = '0;
        bytes_left_next    = '0;
        format_code_next   = '0;
        channel_count_next = '0;
        rate_value_next    = '0;
        sample_bits_next   = '0;
        fmt_seen_next      = 1'b0;
        pcm_count_next     = '0;
        body_offset_next   = '0;
        cur                = '0;
        if (file_length < MIN_LEN) begin
          rep    = 1'b1;
          rep_st = ST_SHORT;
        end else begin
          phase_next = PH_SIG;
          go         = 1'b1;
        end
      end else if (phase != PH_IDLE) begin
        go = 1'b1;
      end
    end

    nxt      = {1'b0, cur} + 33'd1;
    hdr_fits = ({1'b0, nxt} + 34'd8) <= {2'b0, file_length};
    tag      = header_shift_next[63:32];
    size     = '0;
    room     = '0;
    dlen     = '0;
    skip     = '0;

    if (go) begin
      unique case (phase_next)
        PH_SIG: begin
          header_shift_next = {header_shift_next[55:0], b};
          if (cur == 32'd3 && header_shift_next[31:0] != TAG_RIFF) begin
            rep = 1'b1; rep_st = ST_NO_RIFF; phase_next = PH_IDLE;
          end else if (cur >= 32'd11) begin
            if (header_shift_next[31:0] != TAG_WAVE) begin
              rep = 1'b1; rep_st = ST_NO_WAVE; phase_next = PH_IDLE;
            end else if (!hdr_fits) begin
              rep = 1'b1; rep_st = ST_NO_CHUNK; phase_next = PH_IDLE;
            end else begin
              phase_next = PH_HDR; bytes_left_next = 33'd8; header_shift_next = '0;
            end
          end
        end
        PH_HDR: begin
          header_shift_next = {header_shift_next[55:0], b};
          if (bytes_left_next != '0) bytes_left_next = bytes_left_next - 33'd1;
          tag  = header_shift_next[63:32];
          size = {header_shift_next[7:0], header_shift_next[15:8],
                  header_shift_next[23:16], header_shift_next[31:24]};
          room = ({1'b0, file_length} > nxt) ? ({2'b0, file_length} - {1'b0, nxt}) : '0;
          dlen = ({2'b0, size} <= room) ? {1'b0, size} : room[32:0];
          skip = ({1'b0, size} + 33'd1) & ~33'd1;
          if (bytes_left_next == '0) begin
            if (tag == TAG_DATA) begin
              // first data chunk decides; validate the captured format
              if (!fmt_seen_next) begin
                rep = 1'b1; rep_st = ST_NO_CHUNK; phase_next = PH_IDLE;
              end else if (format_code_next != FMT_PCM) begin
                rep = 1'b1; rep_st = ST_NOT_PCM; phase_next = PH_IDLE;
              end else if (channel_count_next != CH_MONO) begin
                rep = 1'b1; rep_st = ST_NOT_MONO; phase_next = PH_IDLE;
              end else if (sample_bits_next != BITS_8) begin
                rep = 1'b1; rep_st = ST_NOT_8BIT; phase_next = PH_IDLE;
              end else if (dlen == '0) begin
                rep = 1'b1; rep_st = ST_OK; phase_next = PH_IDLE;
              end else begin
                phase_next = PH_DATA; bytes_left_next = dlen;
              end
            end else if (tag == TAG_FMT && size >= FMT_MIN) begin
              fmt_seen_next    = 1'b1;
              body_offset_next = '0;
              phase_next       = PH_FMT;
              bytes_left_next  = skip;
            end else if (skip == '0) begin
              if (!hdr_fits) begin
                rep = 1'b1; rep_st = ST_NO_CHUNK; phase_next = PH_IDLE;
              end else begin
                phase_next = PH_HDR; bytes_left_next = 33'd8; header_shift_next = '0;
              end
            end else begin
              phase_next = PH_SKIP; bytes_left_next = skip;
            end
          end
        end
        PH_FMT, PH_SKIP: begin
          if (phase_next == PH_FMT) begin
            unique case (body_offset_next)
              5'd0:  format_code_next[7:0]   = b;
              5'd1:  format_code_next[15:8]  = b;
              5'd2:  channel_count_next[7:0]  = b;
              5'd3:  channel_count_next[15:8] = b;
              5'd4:  rate_value_next[7:0]    = b;
              5'd5:  rate_value_next[15:8]   = b;
              5'd6:  rate_value_next[23:16]  = b;
              5'd7:  rate_value_next[31:24]  = b;
              5'd14: sample_bits_next[7:0]   = b;
              5'd15: sample_bits_next[15:8]  = b;
              default: ;
            endcase
            if (body_offset_next < FMT_OFS_MAX) body_offset_next = body_offset_next + 5'd1;
          end
          if (bytes_left_next != '0) bytes_left_next = bytes_left_next - 33'd1;
          if (bytes_left_next == '0) begin
            if (!hdr_fits) begin
              rep = 1'b1; rep_st = ST_NO_CHUNK; phase_next = PH_IDLE;
            end else begin
              phase_next = PH_HDR; bytes_left_next = 33'd8; header_shift_next = '0;
            end
          end
        end
        PH_DATA: begin
          pcm_out        = 1'b1;
          pcm_count_next = pcm_count_next + 32'd1;
          if (bytes_left_next != '0) bytes_left_next = bytes_left_next - 33'd1;
          if (bytes_left_next == '0) begin
            rep = 1'b1; rep_st = ST_OK; phase_next = PH_IDLE;
          end
        end
        default: phase_next = PH_IDLE;
      endcase

      byte_position_next = nxt[31:0];

      // file end reached while still parsing
      if (phase_next != PH_IDLE && nxt >= {1'b0, file_length}) begin
        rep    = 1'b1;
        rep_st = (phase_next == PH_DATA) ? ST_OK : ST_NO_CHUNK;
        phase_next = PH_IDLE;
      end
    end
  end

  always_comb begin
    res_pcm             = '0;
    res_pcm.kind        = KIND_PCM;
    res_pcm.pcm_byte    = b;
    res_pcm.last        = !rep;
    res_rep             = '0;
    res_rep.kind        = KIND_REPORT;
    res_rep.last        = 1'b1;
    res_rep.status      = rep_st;
    res_rep.pcm_rate    = (rep_st == ST_OK) ? rate_value_next : '0;
    res_rep.pcm_length  = (rep_st == ST_OK) ? pcm_count_next : '0;
    res0  = pcm_out ? res_pcm : res_rep;
    res1  = res_rep;
    push0 = pcm_out || rep;
    push1 = pcm_out && rep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length   <= '0;
      phase         <= PH_IDLE;
      byte_position <= '0;
      header_shift  <= '0;
      bytes_left    <= '0;
      format_code   <= '0;
      channel_count <= '0;
      rate_value    <= '0;
      sample_bits   <= '0;
      fmt_seen      <= 1'b0;
      pcm_count     <= '0;
      body_offset   <= '0;
    end else begin
      if (cfg_wr_en) file_length <= cfg_wr_data;
      phase         <= phase_next;
      byte_position <= byte_position_next;
      header_shift  <= header_shift_next;
      bytes_left    <= bytes_left_next;
      format_code   <= format_code_next;
      channel_count <= channel_count_next;
      rate_value    <= rate_value_next;
      sample_bits   <= sample_bits_next;
      fmt_seen      <= fmt_seen_next;
      pcm_count     <= pcm_count_next;
      body_offset   <= body_offset_next;
    end
  end

  // result queue
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign head     = mem[rd_ptr];
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;
  assign m_tdata  = {5'b0, head.pcm_length, head.pcm_rate, head.status, head.pcm_byte};

  always_ff @(posedge clk) begin
    if (push0) mem[wr_ptr] <= res0;
    if (push1) mem[wr_ptr + FIFO_AW'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push0) + FIFO_AW'(push1);
      if (pop) rd_ptr <= rd_ptr + FIFO_AW'(1);
      count <= count + (FIFO_AW + 1)'(push0) + (FIFO_AW + 1)'(push1)
                     - (FIFO_AW + 1)'(pop);
    end
  end

  `WCP_ASSERT_NEVER(a_fifo_bound, clk, rst, count > (FIFO_AW + 1)'(FIFO_DEPTH))
  `WCP_ASSERT_IMPLY(a_report_last, clk, rst, m_tvalid && m_tuser, m_tlast)
  `WCP_ASSERT_IMPLY(a_pcm_clean, clk, rst, m_tvalid && !m_tuser, m_tdata[79:8] == '0)
  `WCP_ASSERT_IMPLY(a_no_accept_full, clk, rst, s_tvalid && s_tready, count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2))

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top
  import wcp_pkg::*;
();

  // Expected-result store for the parser, fed with every accepted request byte.
  class wav_scoreboard;
    logic [31:0] flen;
    phase_t      ph;
    logic [31:0] pos;
    logic [63:0] shift;
    logic [32:0] left;
    logic [15:0] fcode;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    logic        seen;
    logic [31:0] pcm_cnt;
    logic [4:0]  ofs;
    result_t     due_q[$];
    result_t     step_q[$];
    int          errors;

    function new();
      flen = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      ph = PH_IDLE;
      pos = '0;
      shift = '0;
      left = '0;
      fcode = '0;
      chans = '0;
      rate = '0;
      bits = '0;
      seen = 1'b0;
      pcm_cnt = '0;
      ofs = '0;
    endfunction

    function void set_length(logic [31:0] v);
      flen = v;
    endfunction

    function bit idle();
      return ph == PH_IDLE;
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction

    function void emit(logic kind, logic [7:0] b, logic [2:0] st, logic [31:0] r,
                       logic [31:0] n);
      result_t x;
      x.kind = kind;
      x.last = 1'b0;
      x.pcm_byte = b;
      x.status = st;
      x.pcm_rate = r;
      x.pcm_length = n;
      step_q.push_back(x);
    endfunction

    function void report(logic [2:0] st);
      ph = PH_IDLE;
      if (st == ST_OK) emit(KIND_REPORT, 8'h00, ST_OK, rate, pcm_cnt);
      else emit(KIND_REPORT, 8'h00, st, 32'd0, 32'd0);
    endfunction

    function void open_header(logic [32:0] at);
      if (at + 33'd8 > {1'b0, flen}) begin
        report(ST_NO_CHUNK);
      end else begin
        ph = PH_HDR;
        left = 33'd8;
        shift = '0;
      end
    endfunction

    function void take_fmt(logic [7:0] b);
      case (ofs)
        5'd0: fcode[7:0] = b;
        5'd1: fcode[15:8] = b;
        5'd2: chans[7:0] = b;
        5'd3: chans[15:8] = b;
        5'd4, 5'd5, 5'd6, 5'd7: rate[(ofs - 5'd4) * 8 +: 8] = b;
        5'd14: bits[7:0] = b;
        5'd15: bits[15:8] = b;
        default: ;
      endcase
      if (ofs < FMT_OFS_MAX) ofs = ofs + 5'd1;
    endfunction

    function void close_header(logic [32:0] nxt);
      logic [31:0] tag;
      logic [31:0] w;
      logic [31:0] size;
      logic [32:0] room;
      logic [32:0] len;
      logic [32:0] skip;
      tag = shift[63:32];
      w = shift[31:0];
      size = {w[7:0], w[15:8], w[23:16], w[31:24]};
      if (tag == TAG_DATA) begin
        room = ({1'b0, flen} > nxt) ? {1'b0, flen} - nxt : 33'd0;
        len = ({1'b0, size} <= room) ? {1'b0, size} : room;
        if (!seen) report(ST_NO_CHUNK);
        else if (fcode != FMT_PCM) report(ST_NOT_PCM);
        else if (chans != CH_MONO) report(ST_NOT_MONO);
        else if (bits != BITS_8) report(ST_NOT_8BIT);
        else if (len == 33'd0) report(ST_OK);
        else begin
          ph = PH_DATA;
          left = len;
        end
      end else begin
        // round the body up to an even length
        skip = ({1'b0, size} + 33'd1) & ~33'd1;
        if (tag == TAG_FMT && size >= FMT_MIN) begin
          seen = 1'b1;
          ofs = '0;
          ph = PH_FMT;
          left = skip;
        end else if (skip == 33'd0) begin
          open_header(nxt);
        end else begin
          ph = PH_SKIP;
          left = skip;
        end
      end
    endfunction

    function void seal();
      result_t x;
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      while (step_q.size() > 0) begin
        x = step_q.pop_front();
        due_q.push_back(x);
      end
    endfunction

    function void note_request(logic first, logic [7:0] b);
      logic [32:0] cur;
      step_q.delete();
      if (first) begin
        restart();
        if (flen < MIN_LEN) begin
          report(ST_SHORT);
          seal();
          return;
        end
        ph = PH_SIG;
      end else if (ph == PH_IDLE) begin
        return;
      end
      cur = {1'b0, pos};
      case (ph)
        PH_SIG: begin
          shift = {shift[55:0], b};
          if (cur == 33'd3 && shift[31:0] != TAG_RIFF) report(ST_NO_RIFF);
          else if (cur >= 33'd11) begin
            if (shift[31:0] != TAG_WAVE) report(ST_NO_WAVE);
            else open_header(cur + 33'd1);
          end
        end
        PH_HDR: begin
          shift = {shift[55:0], b};
          if (left != 0) left = left - 33'd1;
          if (left == 0) close_header(cur + 33'd1);
        end
        PH_FMT, PH_SKIP: begin
          if (ph == PH_FMT) take_fmt(b);
          if (left != 0) left = left - 33'd1;
          if (left == 0) open_header(cur + 33'd1);
        end
        PH_DATA: begin
          emit(KIND_PCM, b, ST_OK, 32'd0, 32'd0);
          pcm_cnt = pcm_cnt + 32'd1;
          if (left != 0) left = left - 33'd1;
          if (left == 0) report(ST_OK);
        end
        default: ph = PH_IDLE;
      endcase
      pos = pos + 32'd1;
      // file end reached while still parsing
      if (ph != PH_IDLE && cur + 33'd1 >= {1'b0, flen})
        report(ph == PH_DATA ? ST_OK : ST_NO_CHUNK);
      seal();
    endfunction

    function void check_result(logic kind, logic last, logic [7:0] b, logic [2:0] st,
                               logic [31:0] r, logic [31:0] n);
      result_t want;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d last %0d byte %02h status %0d rate %08h len %08h",
                   kind, last, b, st, r, n);
        return;
      end
      want = due_q.pop_front();
      if (want.kind !== kind || want.last !== last || want.pcm_byte !== b ||
          want.status !== st || want.pcm_rate !== r || want.pcm_length !== n) begin
        errors++;
        if (errors <= 10) begin
          $display("result differs: expected kind %0d last %0d byte %02h status %0d rate %08h len %08h",
                   want.kind, want.last, want.pcm_byte, want.status, want.pcm_rate,
                   want.pcm_length);
          $display("                got      kind %0d last %0d byte %02h status %0d rate %08h len %08h",
                   kind, last, b, st, r, n);
        end
      end
    endfunction

    function int wrap_up();
      if (due_q.size() > 0) begin
        errors += due_q.size();
        $display("%0d expected results never arrived", due_q.size());
      end
      return errors;
    endfunction
  endclass

  typedef enum int {
    SC_GOOD,
    SC_BAD_RIFF,
    SC_BAD_WAVE,
    SC_NO_FMT,
    SC_SMALL_FMT,
    SC_NOT_PCM,
    SC_NOT_MONO,
    SC_NOT_8BIT,
    SC_LATE_FMT,
    SC_HUGE_SKIP,
    SC_NOISE
  } scen_t;

  localparam int IMG_CAP = 160;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  wav_scoreboard sb = new();
  logic [7:0] wav_img[$];
  bit calm = 1'b0;
  int stall_left = 0;
  int sent_items = 0;

  wav_chunk_parser uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Receiver: random stalls; none begin while calm
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 20) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
      if (m_tvalid && m_tready)
        sb.check_result(m_tuser, m_tlast, m_tdata[7:0], m_tdata[10:8], m_tdata[42:11],
                        m_tdata[74:43]);
    end
  end

  function automatic void put_be32(logic [31:0] v);
    wav_img.push_back(v[31:24]);
    wav_img.push_back(v[23:16]);
    wav_img.push_back(v[15:8]);
    wav_img.push_back(v[7:0]);
  endfunction

  function automatic void put_le16(logic [15:0] v);
    wav_img.push_back(v[7:0]);
    wav_img.push_back(v[15:8]);
  endfunction

  function automatic void put_le32(logic [31:0] v);
    put_le16(v[15:0]);
    put_le16(v[31:16]);
  endfunction

  function automatic void put_random(int n);
    int i;
    for (i = 0; i < n; i++) wav_img.push_back(8'($urandom));
  endfunction

  function automatic void add_fmt(scen_t sc, bit tiny, bit lean);
    logic [31:0] sz;
    logic [15:0] fc;
    logic [15:0] ch;
    logic [15:0] bt;
    if (tiny) sz = $urandom_range(0, 15);
    else if (lean) sz = FMT_MIN;
    else sz = FMT_MIN + $urandom_range(0, 3);
    put_be32(TAG_FMT);
    put_le32(sz);
    if (tiny) begin
      put_random(sz + sz[0]);
      return;
    end
    fc = FMT_PCM;
    ch = CH_MONO;
    bt = BITS_8;
    if (sc == SC_NOT_PCM) begin
      fc = 16'($urandom);
      if (fc == FMT_PCM) fc = 16'h0000;
    end
    if (sc == SC_NOT_MONO) begin
      ch = 16'($urandom);
      if (ch == CH_MONO) ch = 16'h0000;
    end
    if (sc == SC_NOT_8BIT) begin
      bt = 16'($urandom);
      if (bt == BITS_8) bt = 16'd16;
    end
    put_le16(fc);
    put_le16(ch);
    put_le32($urandom);
    put_le32($urandom);
    put_le16(16'($urandom));
    put_le16(bt);
    put_random(sz - FMT_MIN + sz[0]);
  endfunction

  // Build one file image of at most IMG_CAP bytes for the given length
  function automatic void build_file(logic [31:0] flen, scen_t sc, bit lean);
    logic [31:0] tag;
    logic [31:0] sz;
    longint unsigned fl;
    longint unsigned room;
    int i;
    int target;
    fl = flen;
    wav_img.delete();
    tag = TAG_RIFF;
    if (sc == SC_BAD_RIFF) begin
      i = $urandom_range(0, 31);
      tag[i] = ~tag[i];
    end
    put_be32(tag);
    put_le32(flen - 32'd8);
    tag = TAG_WAVE;
    if (sc == SC_BAD_WAVE) begin
      i = $urandom_range(0, 31);
      tag[i] = ~tag[i];
    end
    put_be32(tag);
    if (sc != SC_NOISE) begin
      if (!lean && $urandom_range(0, 2) == 0) begin
        sz = $urandom_range(0, 5);
        put_be32($urandom);
        put_le32(sz);
        put_random(sz + sz[0]);
      end
      if (sc == SC_HUGE_SKIP) begin
        put_be32($urandom);
        put_le32(32'hFFFF_FFFF);
      end else begin
        if (sc != SC_NO_FMT && sc != SC_LATE_FMT) begin
          add_fmt(sc, sc == SC_SMALL_FMT, lean);
          if (!lean && sc == SC_GOOD && $urandom_range(0, 3) == 0) add_fmt(SC_GOOD, 1'b0, 1'b0);
        end
        put_be32(TAG_DATA);
        room = (fl > wav_img.size() + 4) ? fl - (wav_img.size() + 4) : 0;
        if (room > 60) room = 60;
        i = $urandom_range(0, 9);
        if (sc == SC_LATE_FMT) sz = 32'd2;
        else if (i == 0) sz = 32'd0;
        else if (i == 1) sz = 32'hFFFF_FFFF;
        else sz = $urandom_range(0, int'(room) + 3);
        put_le32(sz);
        if (sc == SC_LATE_FMT) begin
          put_random(2);
          add_fmt(SC_GOOD, 1'b0, lean);
        end
      end
    end
    target = (fl > IMG_CAP) ? IMG_CAP : int'(fl);
    if (target < 4) target = 4;
    while (wav_img.size() < target) wav_img.push_back(8'($urandom));
  endfunction

  task automatic send_item(input logic first, input logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(0, 99) < 25) begin
      gap = pick_gap();
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= first;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
  endtask

  // Send the first count bytes of the image, or all of it when shorter
  task automatic send_file(input int count);
    int i;
    for (i = 0; i < count && i < wav_img.size(); i++) begin
      send_item(i == 0, wav_img[i]);
    end
  endtask

  // Hold the request side until every expected result is out, then let the queue drain
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_length(input logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.set_length(v);
    cfg_wr_en <= 1'b0;
  endtask

  // Drop an unfinished file: restart with a bad signature so a report closes it
  task automatic close_parse();
    int i;
    send_item(1'b1, 8'h00);
    for (i = 0; i < 3; i++) send_item(1'b0, 8'h00);
  endtask

  initial begin
    int i;
    int r;
    int cnt;
    logic [31:0] flen;
    scen_t sc;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short files, an ignored byte after the report
    write_length(32'd0);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    settle();
    write_length(MIN_LEN - 32'd1);
    send_item(1'b1, 8'h52);
    settle();

    // every scenario at the minimum length, lean layout
    write_length(MIN_LEN);
    for (i = 0; i <= SC_NOISE; i++) begin
      build_file(MIN_LEN, scen_t'(i), 1'b1);
      send_file(wav_img.size());
    end
    settle();

    // restart in the middle of a file
    write_length(32'd60);
    build_file(32'd60, SC_GOOD, 1'b0);
    send_file(30);
    build_file(32'd60, SC_GOOD, 1'b0);
    send_file(wav_img.size());
    settle();

    write_length(32'hFFFF_FFFF);
    build_file(32'hFFFF_FFFF, SC_GOOD, 1'b1);
    send_file(wav_img.size());
    settle();
    if (!sb.idle()) close_parse();

    while (sent_items < 900) begin
      r = $urandom_range(0, 19);
      if (r == 0) flen = $urandom_range(0, 43);
      else if (r == 1) flen = $urandom;
      else if (r < 4) flen = $urandom_range(65, 160);
      else flen = $urandom_range(44, 72);
      settle();
      write_length(flen);
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(0, 99);
        sc = (r < 55) ? SC_GOOD : scen_t'($urandom_range(1, SC_NOISE));
        build_file(flen, sc, 1'b0);
        cnt = wav_img.size();
        if ($urandom_range(0, 9) == 0) cnt = $urandom_range(1, cnt);
        send_file(cnt);
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) send_item(1'b0, 8'($urandom));
      end
      settle();
      if (!sb.idle()) close_parse();
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.wrap_up() == 0) begin
      $display("wav_chunk_parser: match");
    end else begin
      $display("wav_chunk_parser: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("wav_chunk_parser: mismatch");
    $finish;
  end
endmodule
